### rtl/core/uirq_pkg.sv
// ----------------------------------------------------------------------------
// uirq_pkg
// Shared constants, command codes and controller/datapath interface types
// for the unique index ring queue.
// ----------------------------------------------------------------------------
package uirq_pkg;

	// Default queue depth, fixed field widths, reset size and count limit
	localparam int DEPTH_DEF = 256;
	localparam int VAL_W     = 8;
	localparam int SIZE_W    = 9;
	localparam int COUNT_W   = 9;
	localparam int SIZE_RST  = 256;
	localparam int COUNT_MAX = 511;

	// Operation codes
	localparam logic [1:0] CMD_PUSH  = 2'd0;
	localparam logic [1:0] CMD_POP   = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;        // capture the accepted item
		logic scan_start;  // set up the duplicate scan
		logic scan_step;   // issue one scan read / compare
		logic push_wr;     // store value at rear
		logic pop_rd;      // read front entry
		logic pop_commit;  // retire front entry
		logic clear;       // empty the queue
		logic respond;     // register a result
		logic resp_ok;     // result status
	} uirq_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic [1:0] cmd;
		logic       check;
		logic       full;
		logic       empty;
		logic       dup_hit;
		logic       scan_done;
	} uirq_sts_t;

endpackage

### rtl/core/unique_index_ring_queue_unit.sv
// ----------------------------------------------------------------------------
// unique_index_ring_queue_unit
// Ring-buffer queue of 8-bit index values with an optional duplicate check
// on push; usable as a pool of free slot numbers.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its single result
// appears on ok, popped_value and entry_count for exactly one cycle while
// done is high, and cannot be held off. Clear, a push to a full queue, a pop
// from an empty queue, unused commands and a plain push are answered from
// the decode state; a pop is answered from a pop-wait state after one
// registered read of the slot memory. A push with check_unique on a non-empty
// queue scans the stored entries front to rear through the memory's single
// read port, one entry per cycle, each compare registered behind its read
// (a full queue refuses without a scan); a match ends the scan as soon as
// it is compared. Writing size_in_use empties the queue; it is taken on
// cfg_valid while cfg_ready (the block is idle) is high.
module unique_index_ring_queue_unit #(
	parameter int DEPTH = uirq_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    cmd,
	input  logic [uirq_pkg::VAL_W-1:0]    value,
	input  logic                          check_unique,
	output logic                          done,
	output logic                          ok,
	output logic [uirq_pkg::VAL_W-1:0]    popped_value,
	output logic [uirq_pkg::COUNT_W-1:0]  entry_count,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [uirq_pkg::SIZE_W-1:0]   cfg_data
);

	uirq_pkg::uirq_cmd_t ctl_cmd;
	uirq_pkg::uirq_sts_t dp_sts;
	logic                cfg_we;

	// Take configuration only while idle
	assign cfg_ready = !busy;
	assign cfg_we    = cfg_valid && cfg_ready;

	uirq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (dp_sts),
		.cmd    (ctl_cmd),
		.busy   (busy)
	);

	uirq_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (ctl_cmd),
		.sts          (dp_sts),
		.in_cmd       (cmd),
		.in_value     (value),
		.in_check     (check_unique),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.done         (done),
		.ok           (ok),
		.popped_value (popped_value),
		.entry_count  (entry_count)
	);

	// A result always follows a busy cycle
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a preceding busy cycle");

	// An accepted item makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	// A failed operation returns no popped value
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !ok) |-> (popped_value == '0))
		else $error("failed operation returned a popped value");

	// A size write empties the queue
	a_cfg_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (entry_count == '0))
		else $error("size write did not empty the queue");

endmodule

### rtl/core/uirq_ram.sv
// ----------------------------------------------------------------------------
// uirq_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module uirq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/uirq_ctrl.sv
// ----------------------------------------------------------------------------
// uirq_ctrl
// Controller state machine: decodes each item, sequences the duplicate
// scan and the pop read, and tells the datapath when to answer.
// ----------------------------------------------------------------------------
module uirq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  uirq_pkg::uirq_sts_t sts,
	output uirq_pkg::uirq_cmd_t cmd,
	output logic                busy
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SCAN,
		ST_POP_WAIT
	} state_t;

	state_t state_q;
	state_t state_nx;

	// Next state and datapath commands
	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_nx = ST_DECODE;
				end
			end
			ST_DECODE: begin
				case (sts.cmd)
					uirq_pkg::CMD_PUSH: begin
						if (sts.full) begin
							cmd.respond = 1'b1;
							state_nx    = ST_IDLE;
						end else if (sts.check && !sts.empty) begin
							cmd.scan_start = 1'b1;
							state_nx       = ST_SCAN;
						end else begin
							cmd.push_wr = 1'b1;
							cmd.respond = 1'b1;
							cmd.resp_ok = 1'b1;
							state_nx    = ST_IDLE;
						end
					end
					uirq_pkg::CMD_POP: begin
						if (sts.empty) begin
							cmd.respond = 1'b1;
							state_nx    = ST_IDLE;
						end else begin
							cmd.pop_rd = 1'b1;
							state_nx   = ST_POP_WAIT;
						end
					end
					uirq_pkg::CMD_CLEAR: begin
						cmd.clear   = 1'b1;
						cmd.respond = 1'b1;
						cmd.resp_ok = 1'b1;
						state_nx    = ST_IDLE;
					end
					default: begin
						cmd.respond = 1'b1;
						state_nx    = ST_IDLE;
					end
				endcase
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.dup_hit) begin
					cmd.respond = 1'b1;
					state_nx    = ST_IDLE;
				end else if (sts.scan_done) begin
					cmd.push_wr = 1'b1;
					cmd.respond = 1'b1;
					cmd.resp_ok = 1'b1;
					state_nx    = ST_IDLE;
				end
			end
			ST_POP_WAIT: begin
				cmd.pop_commit = 1'b1;
				cmd.respond    = 1'b1;
				cmd.resp_ok    = 1'b1;
				state_nx       = ST_IDLE;
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// Hold state and the busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy    <= 1'b0;
		end else begin
			state_q <= state_nx;
			busy    <= (state_nx != ST_IDLE);
		end
	end

endmodule

### rtl/core/uirq_dp.sv
// ----------------------------------------------------------------------------
// uirq_dp
// Datapath: slot memory, front/rear pointers, entry count, size register,
// duplicate scan unit and result registers.
// ----------------------------------------------------------------------------
module uirq_dp #(
	parameter int DEPTH = uirq_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  uirq_pkg::uirq_cmd_t           cmd,
	output uirq_pkg::uirq_sts_t           sts,
	input  logic [1:0]                    in_cmd,
	input  logic [uirq_pkg::VAL_W-1:0]    in_value,
	input  logic                          in_check,
	input  logic                          cfg_we,
	input  logic [uirq_pkg::SIZE_W-1:0]   cfg_data,
	output logic                          done,
	output logic                          ok,
	output logic [uirq_pkg::VAL_W-1:0]    popped_value,
	output logic [uirq_pkg::COUNT_W-1:0]  entry_count
);

	localparam int PTR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W    = $clog2(DEPTH + 1);
	localparam int RST_SIZE = (uirq_pkg::SIZE_RST > DEPTH) ? DEPTH : uirq_pkg::SIZE_RST;

	logic [1:0]                 cmd_q;
	logic [uirq_pkg::VAL_W-1:0] value_q;
	logic                       chk_q;
	logic [PTR_W-1:0]           front_q;
	logic [PTR_W-1:0]           rear_q;
	logic [CNT_W-1:0]           count_q;
	logic [CNT_W-1:0]           size_q;
	logic [CNT_W-1:0]           size_nx;
	logic [PTR_W-1:0]           scan_ptr_q;
	logic [CNT_W-1:0]           scan_left_q;
	logic                       cmp_vld_q;
	logic                       scan_issue;
	logic                       done_q;
	logic                       ok_q;
	logic [uirq_pkg::VAL_W-1:0] popped_q;
	logic                       ram_re;
	logic [PTR_W-1:0]           ram_raddr;
	logic [uirq_pkg::VAL_W-1:0] ram_rdata;

	// Advance a pointer, wrapping at the size in use
	function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p,
	                                               input logic [CNT_W-1:0] sz);
		logic [CNT_W-1:0] n;
		n = CNT_W'(p) + CNT_W'(1);
		return (n >= sz) ? '0 : PTR_W'(n);
	endfunction

	// Clamp the written size into 1..DEPTH
	always_comb begin
		if (cfg_data == '0) begin
			size_nx = CNT_W'(1);
		end else if (32'(cfg_data) > 32'(DEPTH)) begin
			size_nx = CNT_W'(DEPTH);
		end else begin
			size_nx = CNT_W'(cfg_data);
		end
	end

	// Capture the accepted item
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q   <= in_cmd;
			value_q <= in_value;
			chk_q   <= in_check;
		end
	end

	// Size register, pointers and entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q  <= CNT_W'(RST_SIZE);
			front_q <= '0;
			rear_q  <= '0;
			count_q <= '0;
		end else if (cfg_we) begin
			size_q  <= size_nx;
			front_q <= '0;
			rear_q  <= '0;
			count_q <= '0;
		end else if (cmd.clear) begin
			front_q <= '0;
			rear_q  <= '0;
			count_q <= '0;
		end else if (cmd.push_wr) begin
			rear_q  <= wrap_next(rear_q, size_q);
			count_q <= count_q + CNT_W'(1);
		end else if (cmd.pop_commit) begin
			front_q <= wrap_next(front_q, size_q);
			count_q <= count_q - CNT_W'(1);
		end
	end

	// Duplicate scan: one read issued per cycle, compared in the cycle after
	assign scan_issue = cmd.scan_step && (scan_left_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_ptr_q  <= '0;
			scan_left_q <= '0;
			cmp_vld_q   <= 1'b0;
		end else if (cmd.scan_start) begin
			scan_ptr_q  <= front_q;
			scan_left_q <= count_q;
			cmp_vld_q   <= 1'b0;
		end else if (cmd.scan_step) begin
			cmp_vld_q <= scan_issue;
			if (scan_issue) begin
				scan_ptr_q  <= wrap_next(scan_ptr_q, size_q);
				scan_left_q <= scan_left_q - CNT_W'(1);
			end
		end
	end

	// Slot memory
	assign ram_re    = cmd.pop_rd || scan_issue;
	assign ram_raddr = cmd.pop_rd ? front_q : scan_ptr_q;

	uirq_ram #(
		.WIDTH (uirq_pkg::VAL_W),
		.DEPTH (DEPTH),
		.AW    (PTR_W)
	) u_ram (
		.clk   (clk),
		.we    (cmd.push_wr),
		.waddr (rear_q),
		.wdata (value_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Status to the controller
	always_comb begin
		sts.cmd       = cmd_q;
		sts.check     = chk_q;
		sts.full      = (count_q >= size_q);
		sts.empty     = (count_q == '0);
		sts.dup_hit   = cmp_vld_q && (ram_rdata == value_q);
		sts.scan_done = (scan_left_q == '0) && !cmp_vld_q;
	end

	// Result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.respond;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.respond) begin
			ok_q     <= cmd.resp_ok;
			popped_q <= cmd.pop_commit ? ram_rdata : '0;
		end
	end

	assign done         = done_q;
	assign ok           = ok_q;
	assign popped_value = popped_q;
	assign entry_count  = (32'(count_q) > uirq_pkg::COUNT_MAX) ?
	                      uirq_pkg::COUNT_W'(uirq_pkg::COUNT_MAX) :
	                      uirq_pkg::COUNT_W'(count_q);

endmodule
